@@ hw/rtl/ltmi_pkg.sv @@
// Shared types and constants of the linear to multi-index decoder.
package ltmi_pkg;

  localparam int MAX_DIMS_DEF       = 8;
  localparam int ADDR_WIDTH_DEF     = 32;
  localparam int DIM_SIZE_WIDTH_DEF = 16;

  localparam int WORD_W    = 32;
  localparam int CFG_W     = 64;
  localparam int FIELD_W   = 16;
  localparam int DIMS_HW   = 8;
  localparam int IDX_W     = 18;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(WORD_W);

  localparam logic [1:0] CMD_IDX_FROM_POS  = 2'd0;
  localparam logic [1:0] CMD_IDX_FROM_ADDR = 2'd1;
  localparam logic [1:0] CMD_POS_FROM_ADDR = 2'd2;
  localparam logic [1:0] CMD_UNUSED        = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ILLEGAL = 2'd1;
  localparam logic [1:0] STAT_OOB     = 2'd2;

  localparam logic [2:0] REG_BASE_ADDRESS      = 3'd0;
  localparam logic [2:0] REG_ELEMENT_BYTES     = 3'd1;
  localparam logic [2:0] REG_TOTAL_BYTES       = 3'd2;
  localparam logic [2:0] REG_DIM_COUNT         = 3'd3;
  localparam logic [2:0] REG_DIM_SIZES_LOW     = 3'd4;
  localparam logic [2:0] REG_DIM_SIZES_HIGH    = 3'd5;
  localparam logic [2:0] REG_LOWER_BOUNDS_LOW  = 3'd6;
  localparam logic [2:0] REG_LOWER_BOUNDS_HIGH = 3'd7;

  localparam logic [CFG_W-1:0] DIM_SIZES_RESET = 64'h0001_0001_0001_0001;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_CHECK,
    S_ADDR,
    S_DIM_CHECK,
    S_RUN,
    S_IDX,
    S_EMIT,
    S_STATUS
  } state_t;

endpackage

@@ hw/rtl/linear_to_multi_index_decoder_unit.sv @@
// Top level: row-major linear position / address to multi-index decoder.
//
// Input channel (in_valid / in_stall) carries cmd, position and address; the
// output channel (out_valid / out_stall) carries one beat per dimension with
// status 0 and last on the final dimension, or a single status beat with last
// set. Command 3 is dropped without any output beat.
// The block works on one item at a time; in_stall is high from acceptance
// until the last result has been handed to the output register. All division
// runs through one shared radix-2 divider. Address checks take one more
// division than position commands, then each dimension takes one division
// for the running count and one for the index.
// The output register holds a beat while out_stall is high; the sequencer
// waits on it, and the next item can be accepted while the final beat waits.
// Configuration is written through cfg_write / cfg_index / cfg_data while idle;
// the user must keep to this, the block does not enforce it. Synchronous reset
// returns the registers to base 0, element size 1, total 0, one dimension, all
// sizes 1 and all lower bounds 0, and empties the output register.
module linear_to_multi_index_decoder_unit
  import ltmi_pkg::*;
#(
  parameter int MAX_DIMS       = MAX_DIMS_DEF,
  parameter int ADDR_WIDTH     = ADDR_WIDTH_DEF,
  parameter int DIM_SIZE_WIDTH = DIM_SIZE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [WORD_W-1:0]  position,
  input  logic [WORD_W-1:0]  address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [WORD_W-1:0]  linear_pos,
  output logic [2:0]         dim_number,
  output logic signed [IDX_W-1:0] index_value,
  output logic               last
);

  localparam logic [WORD_W-1:0] ADDR_MASK = (ADDR_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [WORD_W-1:0] QMAX = WORD_W'((64'd1 << DIM_SIZE_WIDTH) - 64'd1);
  localparam logic [3:0]        NDIMS_MAX = 4'(MAX_DIMS);

  // configuration registers
  logic [WORD_W-1:0]  base_address;
  logic [FIELD_W-1:0] element_bytes;
  logic [WORD_W-1:0]  total_bytes;
  logic [3:0]         dim_count;
  logic [CFG_W-1:0]   dim_sizes_low;
  logic [CFG_W-1:0]   dim_sizes_high;
  logic [CFG_W-1:0]   lower_bounds_low;
  logic [CFG_W-1:0]   lower_bounds_high;

  // sequencer and working registers
  state_t             state, state_next;
  logic [1:0]         cmd_reg;
  logic [WORD_W-1:0]  pos_in;
  logic [WORD_W-1:0]  addr_in;
  logic [WORD_W-1:0]  count;
  logic [WORD_W-1:0]  pos;
  logic [WORD_W-1:0]  run;
  logic [WORD_W-1:0]  rem;
  logic [WORD_W-1:0]  qval;
  logic [2:0]         dim;
  logic [1:0]         err_code;

  // shared divider
  logic [WORD_W-1:0]    div_quo;
  logic [WORD_W-1:0]    div_rem;
  logic [WORD_W-1:0]    div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_done;
  logic                 div_start;
  logic [WORD_W-1:0]    div_num_in;
  logic [WORD_W-1:0]    div_den_in;
  logic [WORD_W:0]      div_trial;
  logic                 div_ge;
  logic [WORD_W:0]      div_diff;

  // per-dimension fields
  logic [FIELD_W-1:0] size_field [DIMS_HW];
  logic [FIELD_W-1:0] bound_field [DIMS_HW];
  logic [WORD_W-1:0]  cur_size;
  logic [WORD_W-1:0]  next_size;
  logic [3:0]         ndims;
  logic               any_zero;
  logic               is_last;

  logic               in_accept;
  logic               out_free;
  logic               out_load;
  logic [WORD_W-1:0]  addr_a;
  logic [WORD_W-1:0]  addr_b;
  logic               addr_below;
  logic [DIM_SIZE_WIDTH-1:0] q_sat;
  logic signed [IDX_W-1:0]   lb_ext;
  logic signed [IDX_W-1:0]   idx_calc;

  // result staged for the output register
  logic [1:0]              res_status;
  logic [WORD_W-1:0]       res_pos;
  logic [2:0]              res_dim;
  logic signed [IDX_W-1:0] res_index;
  logic                    res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address      <= '0;
      element_bytes     <= FIELD_W'(1);
      total_bytes       <= '0;
      dim_count         <= 4'd1;
      dim_sizes_low     <= DIM_SIZES_RESET;
      dim_sizes_high    <= DIM_SIZES_RESET;
      lower_bounds_low  <= '0;
      lower_bounds_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS:      base_address      <= cfg_data[WORD_W-1:0];
        REG_ELEMENT_BYTES:     element_bytes     <= cfg_data[FIELD_W-1:0];
        REG_TOTAL_BYTES:       total_bytes       <= cfg_data[WORD_W-1:0];
        REG_DIM_COUNT:         dim_count         <= cfg_data[3:0];
        REG_DIM_SIZES_LOW:     dim_sizes_low     <= cfg_data;
        REG_DIM_SIZES_HIGH:    dim_sizes_high    <= cfg_data;
        REG_LOWER_BOUNDS_LOW:  lower_bounds_low  <= cfg_data;
        REG_LOWER_BOUNDS_HIGH: lower_bounds_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < DIMS_HW / 2; d++) begin
      size_field[d]     = dim_sizes_low[d*FIELD_W +: FIELD_W];
      size_field[d+4]   = dim_sizes_high[d*FIELD_W +: FIELD_W];
      bound_field[d]    = lower_bounds_low[d*FIELD_W +: FIELD_W];
      bound_field[d+4]  = lower_bounds_high[d*FIELD_W +: FIELD_W];
    end
  end

  always_comb begin
    if (dim_count == 4'd0) begin
      ndims = 4'd1;
    end else if (dim_count > NDIMS_MAX) begin
      ndims = NDIMS_MAX;
    end else begin
      ndims = dim_count;
    end
  end

  always_comb begin
    any_zero = 1'b0;
    for (int d = 0; d < DIMS_HW; d++) begin
      if ((4'(d) < ndims) && (size_field[d][DIM_SIZE_WIDTH-1:0] == '0)) begin
        any_zero = 1'b1;
      end
    end
  end

  assign cur_size  = WORD_W'(size_field[dim][DIM_SIZE_WIDTH-1:0]);
  assign next_size = WORD_W'(size_field[3'(dim + 3'd1)][DIM_SIZE_WIDTH-1:0]);
  assign is_last   = (({1'b0, dim} + 4'd1) == ndims);

  assign addr_a     = addr_in & ADDR_MASK;
  assign addr_b     = base_address & ADDR_MASK;
  assign addr_below = (addr_a < addr_b);

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // divider datapath: one quotient bit per cycle
  assign div_done  = (div_cnt == '0);
  assign div_trial = {div_rem, div_quo[WORD_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den});
  assign div_diff  = div_trial - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= DIV_STEPS;
    end else if (!div_done) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo <= div_num_in;
      div_rem <= '0;
      div_den <= div_den_in;
    end else if (!div_done) begin
      div_quo <= {div_quo[WORD_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[WORD_W-1:0] : div_trial[WORD_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && cmd != CMD_UNUSED) state_next = S_COUNT;
      end
      S_COUNT: begin
        if (div_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_reg == CMD_IDX_FROM_POS) begin
          if (total_bytes == '0 || element_bytes == '0 || pos_in == '0 ||
              pos_in > count) begin
            state_next = S_STATUS;
          end else begin
            state_next = S_DIM_CHECK;
          end
        end else if (element_bytes == '0 || addr_below) begin
          state_next = S_STATUS;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (div_done) begin
          if (div_quo >= count || cmd_reg == CMD_POS_FROM_ADDR) begin
            state_next = S_STATUS;
          end else begin
            state_next = S_DIM_CHECK;
          end
        end
      end
      S_DIM_CHECK: begin
        state_next = any_zero ? S_STATUS : S_RUN;
      end
      S_RUN: begin
        if (div_done) state_next = (div_quo != '0) ? S_IDX : S_EMIT;
      end
      S_IDX: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = is_last ? S_IDLE : S_RUN;
      end
      S_STATUS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // index result: saturated quotient plus signed lower bound
  assign q_sat    = (qval > QMAX) ? QMAX[DIM_SIZE_WIDTH-1:0] : qval[DIM_SIZE_WIDTH-1:0];
  assign lb_ext   = IDX_W'(signed'(bound_field[dim]));
  assign idx_calc = signed'(IDX_W'(q_sat)) + lb_ext;

  // outputs of the sequencer
  always_comb begin
    div_start  = 1'b0;
    div_num_in = total_bytes;
    div_den_in = WORD_W'(element_bytes);
    out_load   = 1'b0;
    res_status = STAT_OK;
    res_pos    = pos;
    res_dim    = dim;
    res_index  = idx_calc;
    res_last   = is_last;
    case (state)
      S_IDLE: begin
        div_start = in_accept && cmd != CMD_UNUSED;
      end
      S_CHECK: begin
        div_num_in = addr_a - addr_b;
        div_start  = (cmd_reg != CMD_IDX_FROM_POS) && element_bytes != '0 && !addr_below;
      end
      S_DIM_CHECK: begin
        div_num_in = count;
        div_den_in = cur_size;
        div_start  = !any_zero;
      end
      S_RUN: begin
        div_num_in = rem;
        div_den_in = div_quo;
        div_start  = div_done && div_quo != '0;
      end
      S_EMIT: begin
        out_load   = out_free;
        div_num_in = run;
        div_den_in = next_size;
        div_start  = out_free && !is_last;
      end
      S_STATUS: begin
        out_load   = out_free;
        res_status = err_code;
        res_dim    = '0;
        res_index  = '0;
        res_last   = 1'b1;
      end
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd_reg <= cmd;
          pos_in  <= position;
          addr_in <= address;
          dim     <= '0;
        end
      end
      S_COUNT: begin
        if (div_done) count <= (element_bytes != '0) ? div_quo : '0;
      end
      S_CHECK: begin
        if (cmd_reg == CMD_IDX_FROM_POS) begin
          pos      <= (state_next == S_DIM_CHECK) ? pos_in : '0;
          err_code <= (total_bytes == '0) ? STAT_ILLEGAL : STAT_OOB;
        end else begin
          pos      <= '0;
          err_code <= STAT_OOB;
        end
      end
      S_ADDR: begin
        if (div_done) begin
          if (div_quo >= count) begin
            pos      <= '0;
            err_code <= STAT_OOB;
          end else begin
            pos      <= div_quo + WORD_W'(1);
            err_code <= STAT_OK;
          end
        end
      end
      S_DIM_CHECK: begin
        if (any_zero) begin
          pos      <= '0;
          err_code <= STAT_OOB;
        end
        rem <= pos - WORD_W'(1);
      end
      S_RUN: begin
        if (div_done) begin
          run  <= div_quo;
          qval <= '0;
        end
      end
      S_IDX: begin
        if (div_done) begin
          qval <= div_quo;
          rem  <= div_rem;
        end
      end
      S_EMIT: begin
        if (out_free && !is_last) dim <= dim + 3'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      linear_pos  <= res_pos;
      dim_number  <= res_dim;
      index_value <= res_index;
      last        <= res_last;
    end
  end

endmodule
